/* src/ipv6_prefix_acl_table_defines.svh */
// Assertion macros for the IPv6 prefix ACL table.
// Used by the top level only; needs no package.
`ifndef IPV6_PREFIX_ACL_TABLE_DEFINES_SVH
`define IPV6_PREFIX_ACL_TABLE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define IPACL_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ipacl: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define IPACL_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ipacl: next-cycle check failed");

`endif

/* src/ipacl_pkg.sv */
// Shared types, constants and helpers for the IPv6 prefix ACL table.
// No dependencies; used by the controller, datapath and top level.
`default_nettype none

package ipacl_pkg;

   localparam int ACL_DEPTH = 32;
   localparam int ADDR_W    = 128;
   localparam int HALF_W    = 64;
   localparam int LEN_W     = 8;
   localparam int CNT_W     = $clog2(ACL_DEPTH + 1);
   localparam int IDX_W     = (ACL_DEPTH > 1) ? $clog2(ACL_DEPTH) : 1;

   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(ADDR_W);

   localparam logic ACTION_ADD   = 1'b0;
   localparam logic ACTION_MATCH = 1'b1;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_DUP  = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;

   typedef struct packed {
      logic              action;
      logic [HALF_W-1:0] addr_high;
      logic [HALF_W-1:0] addr_low;
      logic [LEN_W-1:0]  prefix_len;
   } req_type;

   typedef struct packed {
      logic       hit;
      logic [1:0] status;
   } rsp_type;

   typedef struct packed {
      logic [HALF_W-1:0] addr_high;
      logic [HALF_W-1:0] addr_low;
      logic [LEN_W-1:0]  prefix_len;
   } entry_type;

   // controller -> datapath
   typedef struct packed {
      logic             load;
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
      logic             append;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic             match;
      logic             action;
      logic             full;
      logic [CNT_W-1:0] count;
   } sts_type;

   function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
      return (len > MAX_LEN) ? MAX_LEN : len;
   endfunction

   // Ones in the top len bits; len is at most 128.
   function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
      return ~({ADDR_W{1'b1}} >> len);
   endfunction

endpackage

`default_nettype wire

/* src/ipacl_datapath.sv */
// Datapath of the IPv6 prefix ACL table: request register, entry memory,
// entry count and the masked prefix comparator. Depends on ipacl_pkg.
`default_nettype none

module ipacl_datapath (
   input  wire                     clock,
   input  wire                     reset,
   input  wire ipacl_pkg::req_type req_data,
   input  wire ipacl_pkg::cmd_type cmd,
   output ipacl_pkg::sts_type      sts
);
   import ipacl_pkg::*;

   entry_type        mem [ACL_DEPTH];
   entry_type        rdata_ff;
   req_type          req_ff;
   req_type          req_in;
   logic [CNT_W-1:0] count_ff;
   logic [LEN_W-1:0] cmp_len;
   logic [ADDR_W-1:0] diff;

   always_comb begin
      req_in            = req_data;
      req_in.prefix_len = clamp_len(req_data.prefix_len);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_in;
      end
   end

   // entry memory: one write port at the count, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.append) begin
         mem[count_ff[IDX_W-1:0]] <= '{addr_high:  req_ff.addr_high,
                                       addr_low:   req_ff.addr_low,
                                       prefix_len: req_ff.prefix_len};
      end
      if (cmd.rd_en) begin
         rdata_ff <= mem[cmd.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.append) begin
         count_ff <= count_ff + CNT_W'(1);
      end
   end

   // add uses the new length, match uses the stored one
   always_comb begin
      cmp_len = (req_ff.action == ACTION_ADD) ? req_ff.prefix_len : rdata_ff.prefix_len;
      diff    = {req_ff.addr_high, req_ff.addr_low} ^ {rdata_ff.addr_high, rdata_ff.addr_low};
   end

   assign sts.match  = ((diff & prefix_mask(cmp_len)) == '0);
   assign sts.action = req_ff.action;
   assign sts.full   = (count_ff == CNT_W'(ACL_DEPTH));
   assign sts.count  = count_ff;

endmodule

`default_nettype wire

/* src/ipacl_ctrl.sv */
// Controller of the IPv6 prefix ACL table: walks the stored entries,
// stops at the first match and forms the response. Depends on ipacl_pkg.
`default_nettype none

module ipacl_ctrl (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     start,
   output logic                    busy,
   input  wire ipacl_pkg::sts_type sts,
   output ipacl_pkg::cmd_type      cmd,
   output logic                    rsp_valid,
   output ipacl_pkg::rsp_type      rsp_data
);
   import ipacl_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RESPOND
   } state_type;

   state_type        state_ff;
   logic [CNT_W-1:0] idx_ff;
   logic             pend_ff;
   logic             found_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_ff;
   logic             issue;
   logic             match_now;

   assign issue     = (state_ff == ST_SCAN) && (idx_ff < sts.count);
   assign match_now = pend_ff && sts.match;

   assign busy          = (state_ff != ST_IDLE);
   assign cmd.load      = start && (state_ff == ST_IDLE);
   assign cmd.rd_en     = issue;
   assign cmd.rd_addr   = idx_ff[IDX_W-1:0];
   assign cmd.append    = (state_ff == ST_RESPOND) && (sts.action == ACTION_ADD)
                          && !found_ff && !sts.full;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data      = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         pend_ff      <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  state_ff <= ST_SCAN;
                  idx_ff   <= '0;
                  pend_ff  <= 1'b0;
                  found_ff <= 1'b0;
               end
            end
            ST_SCAN: begin
               pend_ff <= issue;
               if (issue) begin
                  idx_ff <= idx_ff + CNT_W'(1);
               end
               // stop at the first match, or once the last read is compared
               if (match_now) begin
                  found_ff <= 1'b1;
                  pend_ff  <= 1'b0;
                  state_ff <= ST_RESPOND;
               end else if (!issue && !pend_ff) begin
                  state_ff <= ST_RESPOND;
               end
            end
            ST_RESPOND: begin
               rsp_valid_ff <= 1'b1;
               if (sts.action == ACTION_MATCH) begin
                  rsp_ff.hit    <= found_ff;
                  rsp_ff.status <= STATUS_OK;
               end else begin
                  rsp_ff.hit <= 1'b0;
                  if (found_ff) begin
                     rsp_ff.status <= STATUS_DUP;
                  end else if (sts.full) begin
                     rsp_ff.status <= STATUS_FULL;
                  end else begin
                     rsp_ff.status <= STATUS_OK;
                  end
               end
               state_ff <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

/* src/ipv6_prefix_acl_table.sv */
// IPv6 prefix ACL table. A request walks the stored entries from start to
// the response strobe, ending early when a match is found: the walk
// reads one stored entry per cycle through a single memory read port and one
// masked 128-bit comparator. A full table holds 32 entries.
// One request at a time; busy stays high until the response is issued.
// Synchronous reset empties the table (count to zero); the receiver cannot stall.
`default_nettype none

module ipv6_prefix_acl_table (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     start,
   output logic                    busy,
   input  wire ipacl_pkg::req_type req_data,
   output logic                    rsp_valid,
   output ipacl_pkg::rsp_type      rsp_data
);
   import ipacl_pkg::*;

   `include "ipv6_prefix_acl_table_defines.svh"

   cmd_type cmd;
   sts_type sts;

   ipacl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .sts       (sts),
      .cmd       (cmd),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   ipacl_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts)
   );

   `IPACL_ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy)
   `IPACL_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid)
   `IPACL_ASSERT_SAME(a_append_room, clock, reset, cmd.append, !sts.full)
   `IPACL_ASSERT_SAME(a_hit_ok, clock, reset, rsp_valid && rsp_data.hit,
                      rsp_data.status == STATUS_OK)

endmodule

`default_nettype wire
